>>> rtl/dnsenc_pkg.sv
`timescale 1ns / 1ps

package dnsenc_pkg;

	localparam logic       REQ_CHAR    = 1'b0;
	localparam logic       REQ_END     = 1'b1;
	localparam logic [7:0] DOT_CHAR    = 8'd46;
	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] ROOT_BYTE   = 8'd0;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       root_follows;
		logic       last;
		logic       error;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH_LEN,
		ST_FLUSH_BYTE,
		ST_EMIT_ONE
	} state_t;

	typedef struct packed {
		logic req_valid;
		logic req_end;
		logic is_dot;
		logic failed;
		logic label_empty;
		logic label_full;
		logic wire_empty;
		logic overflow;
		logic last_byte;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic ready;
		logic store_char;
		logic set_fail;
		logic start_flush;
		logic flush_final;
		logic start_one;
		logic one_err;
		logic emit_len;
		logic emit_byte;
		logic emit_one;
	} cmd_t;

endpackage

>>> rtl/dnsenc_chan_if.sv
`timescale 1ns / 1ps

interface dnsenc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/dnsenc_ram.sv
`timescale 1ns / 1ps

module dnsenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/dnsenc_ctrl.sv
`timescale 1ns / 1ps

module dnsenc_ctrl
	import dnsenc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	logic char_ok;
	logic dot_flush;
	logic dot_fail;
	logic char_store;
	logic char_fail;
	logic end_in;
	logic end_flush;
	logic end_one;
	logic end_term_ok;

	assign char_ok     = sts.req_valid && (sts.req_end == REQ_CHAR) && !sts.failed;
	assign dot_flush   = char_ok && sts.is_dot && !sts.label_empty && !sts.overflow;
	assign dot_fail    = char_ok && sts.is_dot && (sts.label_empty || sts.overflow);
	assign char_store  = char_ok && !sts.is_dot && !sts.label_full;
	assign char_fail   = char_ok && !sts.is_dot && sts.label_full;
	assign end_in      = sts.req_valid && (sts.req_end == REQ_END);
	assign end_flush   = end_in && !sts.failed && !sts.label_empty && !sts.overflow;
	assign end_one     = end_in && !end_flush;
	assign end_term_ok = !sts.failed && sts.label_empty && !sts.wire_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dot_flush || end_flush) begin
					state_d = ST_FLUSH_LEN;
				end else if (end_one) begin
					state_d = ST_EMIT_ONE;
				end
			end
			ST_FLUSH_LEN: begin
				if (sts.out_free) begin
					state_d = ST_FLUSH_BYTE;
				end
			end
			ST_FLUSH_BYTE: begin
				if (sts.out_free && sts.last_byte) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_ONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready       = 1'b1;
				cmd.store_char  = char_store;
				cmd.set_fail    = dot_fail || char_fail;
				cmd.start_flush = dot_flush || end_flush;
				cmd.flush_final = end_flush;
				cmd.start_one   = end_one;
				cmd.one_err     = !end_term_ok;
			end
			ST_FLUSH_LEN: begin
				cmd.emit_len = sts.out_free;
			end
			ST_FLUSH_BYTE: begin
				cmd.emit_byte = sts.out_free;
			end
			ST_EMIT_ONE: begin
				cmd.emit_one = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/dnsenc_dp.sv
`timescale 1ns / 1ps

module dnsenc_dp
	import dnsenc_pkg::*;
#(
	parameter int MAX_LABEL = 63,
	parameter int MAX_WIRE  = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic req_valid,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int AW  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int LCW = $clog2(MAX_LABEL + 1);
	localparam int WCW = $clog2(MAX_WIRE + 1);

	logic [LCW-1:0] label_count_q;
	logic [WCW-1:0] wire_count_q;
	logic           failed_q;
	logic [AW-1:0]  idx_q;
	logic           final_q;
	logic           err_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic [7:0]     folded;
	logic [7:0]     rdata;
	logic [AW-1:0]  raddr;
	logic [WCW:0]   wire_need;
	logic           last_byte;
	logic           out_free;

	always_comb begin
		folded = req_data.char_code;
		if (req_data.char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
			folded = req_data.char_code + CASE_OFFSET;
		end
	end

	assign wire_need = {1'b0, wire_count_q} + (WCW+1)'(label_count_q) + (WCW+1)'(2);
	assign last_byte = ((LCW'(idx_q) + LCW'(1)) == label_count_q);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign raddr     = (cmd.emit_byte && !last_byte) ? idx_q + AW'(1) :
	                   (cmd.emit_byte ? '0 : idx_q);

	dnsenc_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LABEL)
	) u_label_ram (
		.clk   (clk),
		.we    (cmd.store_char),
		.waddr (label_count_q[AW-1:0]),
		.wdata (folded),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		sts.req_valid   = req_valid;
		sts.req_end     = req_data.req_type;
		sts.is_dot      = (req_data.char_code == DOT_CHAR);
		sts.failed      = failed_q;
		sts.label_empty = (label_count_q == '0);
		sts.label_full  = (label_count_q >= LCW'(MAX_LABEL));
		sts.wire_empty  = (wire_count_q == '0);
		sts.overflow    = (wire_need > (WCW+1)'(MAX_WIRE));
		sts.last_byte   = last_byte;
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= '0;
			wire_count_q  <= '0;
			failed_q      <= 1'b0;
			idx_q         <= '0;
			final_q       <= 1'b0;
			err_q         <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cmd.store_char) begin
				label_count_q <= label_count_q + LCW'(1);
			end
			if (cmd.set_fail) begin
				failed_q <= 1'b1;
			end
			if (cmd.start_flush) begin
				final_q <= cmd.flush_final;
			end
			if (cmd.start_one) begin
				err_q <= cmd.one_err;
			end
			if (cmd.emit_byte) begin
				if (last_byte) begin
					idx_q         <= '0;
					label_count_q <= '0;
					if (final_q) begin
						wire_count_q <= '0;
						failed_q     <= 1'b0;
					end else begin
						wire_count_q <= wire_count_q + WCW'(1) + WCW'(label_count_q);
					end
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			if (cmd.emit_one) begin
				label_count_q <= '0;
				wire_count_q  <= '0;
				failed_q      <= 1'b0;
			end
			if (cmd.emit_len || cmd.emit_byte || cmd.emit_one) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_len) begin
			rsp_q.wire_byte    <= 8'(label_count_q);
			rsp_q.root_follows <= final_q && (label_count_q == '0);
			rsp_q.last         <= final_q && (label_count_q == '0);
			rsp_q.error        <= 1'b0;
		end else if (cmd.emit_byte) begin
			rsp_q.wire_byte    <= rdata;
			rsp_q.root_follows <= final_q && last_byte;
			rsp_q.last         <= final_q && last_byte;
			rsp_q.error        <= 1'b0;
		end else if (cmd.emit_one) begin
			rsp_q.wire_byte    <= ROOT_BYTE;
			rsp_q.root_follows <= 1'b0;
			rsp_q.last         <= 1'b1;
			rsp_q.error        <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_label_bound: assert property (@(posedge clk) disable iff (!arst_n)
		label_count_q <= LCW'(MAX_LABEL))
		else $error("label count exceeds the label limit");

	a_wire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wire_count_q < WCW'(MAX_WIRE))
		else $error("wire count reached the wire limit");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_len || cmd.emit_byte || cmd.emit_one) |-> out_free)
		else $error("output register overwritten while still held");

	a_byte_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte |-> (label_count_q != '0))
		else $error("label byte sent from an empty label");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_char |=> (label_count_q == $past(label_count_q) + LCW'(1)))
		else $error("label count did not advance on a stored character");

endmodule

>>> rtl/dns_name_wire_encoder.sv
`timescale 1ns / 1ps

// The encoder turns a dotted host name into its DNS wire form. The req channel
// carries one word per character (req_type 0) and one end word (req_type 1)
// that closes the name. The rsp channel carries the wire bytes, each with
// root_follows, last and error flags; the final word of a name has last set.
// A character word is taken and gives no output; upper case
// letters are folded to lower case and kept in the label RAM.
// A dot or end word after a nonempty label that fits starts a flush that sends
// the length byte and then the label bytes, one word per cycle while the
// receiver takes them, read back through the label RAM port.
// An end word that does not start a flush sends one terminator or error word.
// The start registers the controller state, then the first output word.
// Input is not taken while a flush or a single result is in progress.
// When the receiver stalls, the output register holds its word and the flush
// waits; no word is lost or repeated.
// Reset clears the counters, the error flag and the output valid; the label
// RAM needs no clearing.

module dns_name_wire_encoder
	import dnsenc_pkg::*;
#(
	parameter int MAX_LABEL = 63,
	parameter int MAX_WIRE  = 256
) (
	input logic           clk,
	input logic           arst_n,
	dnsenc_chan_if.sink   req,
	dnsenc_chan_if.source rsp
);

	cmd_t cmd;
	sts_t sts;
	req_t req_data;
	rsp_t rsp_data;
	logic rsp_valid;

	assign req_data    = req.payload;
	assign req.ready   = cmd.ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_data;

	dnsenc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dnsenc_dp #(
		.MAX_LABEL (MAX_LABEL),
		.MAX_WIRE  (MAX_WIRE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_valid (req.valid),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data)
	);

endmodule

>>> bench/dnsenc_name_checker.sv
`timescale 1ns / 1ps

module dnsenc_name_checker
	import dnsenc_pkg::*;
#(
	parameter int MAX_LABEL = 63,
	parameter int MAX_WIRE  = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_word,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_word,
	output int   fail_count,
	output int   pending_words
);

	logic [7:0] label_buf [MAX_LABEL];
	int         label_len;
	int         wire_len;
	bit         name_failed;
	rsp_t       expected_words [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void push_word(input logic [7:0] b, input logic rf, input logic lst,
		input logic err);
		rsp_t w;
		w.wire_byte    = b;
		w.root_follows = rf;
		w.last         = lst;
		w.error        = err;
		expected_words.push_back(w);
	endfunction

	// Returns 0 when the label would push the wire form past its limit; nothing is sent then.
	function automatic bit emit_label(input bit closing);
		int i;
		bit at_end;
		if (wire_len + label_len + 2 > MAX_WIRE) begin
			return 1'b0;
		end
		push_word(8'(label_len), 1'b0, 1'b0, 1'b0);
		for (i = 0; i < label_len; i++) begin
			at_end = closing && (i == label_len - 1);
			push_word(label_buf[i], at_end, at_end, 1'b0);
		end
		wire_len += label_len + 1;
		label_len = 0;
		return 1'b1;
	endfunction

	function automatic void predict_request(input req_t w);
		logic [7:0] c;
		c = w.char_code;
		if (w.req_type == REQ_CHAR) begin
			if (name_failed) begin
				return;
			end
			if (c == DOT_CHAR) begin
				if (label_len == 0) begin
					name_failed = 1'b1;
				end else if (!emit_label(1'b0)) begin
					name_failed = 1'b1;
				end
			end else if (label_len >= MAX_LABEL) begin
				name_failed = 1'b1;
			end else begin
				if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
					c = c + CASE_OFFSET;
				end
				label_buf[label_len] = c;
				label_len++;
			end
		end else begin
			if (!name_failed && label_len > 0 && emit_label(1'b1)) begin
			end else if (!name_failed && label_len == 0 && wire_len > 0) begin
				push_word(ROOT_BYTE, 1'b0, 1'b1, 1'b0);
			end else begin
				push_word(ROOT_BYTE, 1'b0, 1'b1, 1'b1);
			end
			label_len   = 0;
			wire_len    = 0;
			name_failed = 1'b0;
		end
	endfunction

	task automatic check_word(input rsp_t got);
		rsp_t want;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected output word %h", got));
			return;
		end
		want = expected_words.pop_front();
		if (got.wire_byte !== want.wire_byte) begin
			report_mismatch($sformatf("wire_byte %0d, expected %0d", got.wire_byte,
				want.wire_byte));
		end
		if (got.root_follows !== want.root_follows) begin
			report_mismatch($sformatf("root_follows %b, expected %b", got.root_follows,
				want.root_follows));
		end
		if (got.last !== want.last) begin
			report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
		end
		if (got.error !== want.error) begin
			report_mismatch($sformatf("error %b, expected %b", got.error, want.error));
		end
	endtask

	// Output words belong to earlier input words, so they are checked before the new prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count  = 0;
			label_len   = 0;
			wire_len    = 0;
			name_failed = 1'b0;
			expected_words.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_word(rsp_word);
			end
			if (req_valid && req_ready) begin
				predict_request(req_word);
			end
		end
		pending_words = expected_words.size();
	end

endmodule

>>> bench/tb_dns_name_wire_encoder.sv
`timescale 1ns / 1ps

module tb_dns_name_wire_encoder;
	import dnsenc_pkg::*;

	localparam int MAX_LABEL  = 63;
	localparam int MAX_WIRE   = 256;
	localparam int NAME_WORDS = 430;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_words;
	int   words_sent;
	int   stall_left = 0;
	bit   calm = 1'b0;
	bit   did_boundary;

	dnsenc_chan_if #(.payload_t(req_t)) req_ch ();
	dnsenc_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	dns_name_wire_encoder #(
		.MAX_LABEL(MAX_LABEL),
		.MAX_WIRE (MAX_WIRE)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	dnsenc_name_checker #(
		.MAX_LABEL(MAX_LABEL),
		.MAX_WIRE (MAX_WIRE)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.req_word     (req_ch.payload),
		.rsp_valid    (rsp_ch.valid),
		.rsp_ready    (rsp_ch.ready),
		.rsp_word     (rsp_ch.payload),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
			4, 5: c = CHAR_UPPER_A + CASE_OFFSET + 8'($urandom_range(0, 25));
			6: c = 8'($urandom_range(48, 57));
			7: c = "-";
			default: begin
				c = 8'($urandom);
				if (c == DOT_CHAR) begin
					c = ROOT_BYTE;
				end
			end
		endcase
		return c;
	endfunction

	// Quiet stretches with no idling on either side alternate with noisy ones.
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) begin
			calm <= !calm;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			stall_left   <= pick_gap();
		end
	end

	task automatic send_word(input logic kind, input logic [7:0] code);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= '{req_type: kind, char_code: code};
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_label(input int len);
		int i;
		for (i = 0; i < len; i++) begin
			send_word(REQ_CHAR, pick_char());
		end
	endtask

	// Three full labels and a fourth that either just fits or overflows by one byte.
	task automatic send_boundary_name();
		int i;
		for (i = 0; i < 3; i++) begin
			send_label(MAX_LABEL);
			send_word(REQ_CHAR, DOT_CHAR);
		end
		send_label(MAX_WIRE - 3 * (MAX_LABEL + 1) - 2 + $urandom_range(0, 1));
		if ($urandom_range(0, 1) == 1) begin
			send_word(REQ_CHAR, DOT_CHAR);
		end
		send_word(REQ_END, 8'($urandom));
	endtask

	task automatic send_random_name();
		int kind;
		int labels;
		int i;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			labels = $urandom_range(1, 4);
			for (i = 0; i < labels; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					send_label($urandom_range(MAX_LABEL - 7, MAX_LABEL));
				end else begin
					send_label($urandom_range(1, 8));
				end
				if (i < labels - 1 || $urandom_range(0, 3) == 0) begin
					send_word(REQ_CHAR, DOT_CHAR);
				end
			end
		end else if (kind < 78) begin
			send_label($urandom_range(0, 3));
			send_word(REQ_CHAR, DOT_CHAR);
			send_word(REQ_CHAR, DOT_CHAR);
			send_label($urandom_range(0, 3));
		end else if (kind < 84) begin
			send_label($urandom_range(MAX_LABEL + 1, MAX_LABEL + 4));
			if ($urandom_range(0, 1) == 1) begin
				send_word(REQ_CHAR, DOT_CHAR);
				send_label($urandom_range(1, 3));
			end
		end else if (kind < 88) begin
		end else begin
			labels = $urandom_range(1, 12);
			for (i = 0; i < labels; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_word(REQ_END, 8'($urandom));
				end else if ($urandom_range(0, 3) == 0) begin
					send_word(REQ_CHAR, DOT_CHAR);
				end else begin
					send_word(REQ_CHAR, 8'($urandom));
				end
			end
		end
		send_word(REQ_END, 8'($urandom));
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		words_sent     = 0;
		did_boundary   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty name is an error.
		send_word(REQ_END, 8'hff);
		// Both case limits, a zero byte and the top byte value.
		send_word(REQ_CHAR, CHAR_UPPER_A);
		send_word(REQ_CHAR, CHAR_UPPER_Z);
		send_word(REQ_CHAR, DOT_CHAR);
		send_word(REQ_CHAR, 8'h00);
		send_word(REQ_CHAR, 8'hff);
		send_word(REQ_END, 8'h00);
		// A leading dot fails the name and the following character is ignored.
		send_word(REQ_CHAR, DOT_CHAR);
		send_word(REQ_CHAR, "x");
		send_word(REQ_END, DOT_CHAR);
		// Characters just outside the upper case range, then one trailing dot.
		send_word(REQ_CHAR, CHAR_UPPER_A - 8'd1);
		send_word(REQ_CHAR, CHAR_UPPER_Z + 8'd1);
		send_word(REQ_CHAR, DOT_CHAR);
		send_word(REQ_END, 8'h55);
		// Two dots in a row give an empty label.
		send_word(REQ_CHAR, "q");
		send_word(REQ_CHAR, DOT_CHAR);
		send_word(REQ_CHAR, DOT_CHAR);
		send_word(REQ_END, 8'haa);
		send_word(REQ_CHAR, "Y");
		send_word(REQ_END, 8'h01);

		while (words_sent < NAME_WORDS) begin
			if (!did_boundary && words_sent >= NAME_WORDS / 3) begin
				send_boundary_name();
				did_boundary = 1'b1;
			end else begin
				send_random_name();
			end
		end
		req_ch.valid <= 1'b0;

		// The checker predicts the last word at the edge that accepts it.
		@(posedge clk);
		wait (pending_words == 0);
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending_words == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

endmodule
